/* rtl/core/cle_pkg.sv */
// ----------------------------------------------------------------------------
// cle_pkg
// Types, character codes and the echo sequence table shared by the console
// line editor modules.
// ----------------------------------------------------------------------------
package cle_pkg;

    // Width of the fill count and of the delivered length.
    localparam int unsigned FILL_W = 6;
    // Width of an index into the echo sequence table.
    localparam int unsigned TAB_W  = 5;

    localparam logic [7:0] CH_ETX = 8'h03;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_LF  = 8'h0a;
    localparam logic [7:0] CH_FF  = 8'h0c;
    localparam logic [7:0] CH_CR  = 8'h0d;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TLD = 8'h7e;
    localparam logic [7:0] CH_DEL = 8'h7f;

    // Start and end entries of each sequence in the echo table.
    localparam logic [TAB_W-1:0] TAB_NL        = 5'd0;
    localparam logic [TAB_W-1:0] TAB_INTR      = 5'd1;
    localparam logic [TAB_W-1:0] TAB_INTR_END  = 5'd3;
    localparam logic [TAB_W-1:0] TAB_ERASE     = 5'd4;
    localparam logic [TAB_W-1:0] TAB_ERASE_END = 5'd6;
    localparam logic [TAB_W-1:0] TAB_CLEAR     = 5'd7;
    localparam logic [TAB_W-1:0] TAB_CLEAR_END = 5'd20;
    localparam logic [TAB_W-1:0] TAB_BELL      = 5'd21;

    typedef enum logic [1:0] {
        KIND_ECHO = 2'd0,
        KIND_LINE = 2'd1,
        KIND_END  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHAR,
        ST_TAB,
        ST_LINE,
        ST_END
    } t_state;

    // What one received byte does: state updates and the results to send.
    typedef struct packed {
        logic              busy;
        logic              use_char;
        logic [TAB_W-1:0]  tab_start;
        logic [TAB_W-1:0]  tab_end;
        logic [FILL_W-1:0] line_len;
        t_kind             line_kind;
        logic              has_end;
        logic              mem_wr;
        logic [FILL_W-1:0] fill_next;
        logic              cr_next;
    } t_plan;

    // Newline, interrupt, erase, clear screen followed by the prompt, bell.
    function automatic logic [7:0] echo_rom(input logic [TAB_W-1:0] idx);
        logic [7:0] b;
        unique case (idx)
            5'd0:    b = 8'h0a;
            5'd1:    b = 8'h5e;
            5'd2:    b = 8'h43;
            5'd3:    b = 8'h0a;
            5'd4:    b = 8'h08;
            5'd5:    b = 8'h20;
            5'd6:    b = 8'h08;
            5'd7:    b = 8'h1b;
            5'd8:    b = 8'h5b;
            5'd9:    b = 8'h32;
            5'd10:   b = 8'h4a;
            5'd11:   b = 8'h1b;
            5'd12:   b = 8'h5b;
            5'd13:   b = 8'h48;
            5'd14:   b = 8'h70;
            5'd15:   b = 8'h69;
            5'd16:   b = 8'h63;
            5'd17:   b = 8'h6f;
            5'd18:   b = 8'h78;
            5'd19:   b = 8'h3e;
            5'd20:   b = 8'h20;
            5'd21:   b = 8'h07;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

/* rtl/core/cle_decode.sv */
// ----------------------------------------------------------------------------
// cle_decode
// Classifies a received byte against the current line state and produces
// the plan of state updates and results for it.
// ----------------------------------------------------------------------------
module cle_decode #(
    parameter int unsigned LINE_SIZE = 32
) (
    input  logic [7:0]                  i_byte,
    input  logic [cle_pkg::FILL_W-1:0]  i_fill,
    input  logic                        i_cr,
    input  logic [7:0]                  i_cap,
    output cle_pkg::t_plan              o_plan
);

    logic [7:0]                 cap_m1;
    logic [cle_pkg::FILL_W-1:0] dlv_len;
    logic                       has_room;

    assign cap_m1   = i_cap - 8'd1;
    assign has_room = i_fill < cle_pkg::FILL_W'(LINE_SIZE - 1);

    // Delivered length is the fill count capped at the capacity less one (zero at capacity zero).
    always_comb begin
        priority if (i_cap == 8'd0) begin
            dlv_len = '0;
        end else if ({2'b00, i_fill} > cap_m1) begin
            dlv_len = cap_m1[cle_pkg::FILL_W-1:0];
        end else begin
            dlv_len = i_fill;
        end
    end

    always_comb begin
        o_plan           = '0;
        o_plan.line_kind = cle_pkg::KIND_ECHO;
        o_plan.fill_next = i_fill;
        o_plan.cr_next   = 1'b0;
        priority if (i_byte == cle_pkg::CH_LF && i_cr) begin
            // Second half of a CR LF pair: swallowed.
            o_plan.busy = 1'b0;
        end else if (i_byte == cle_pkg::CH_CR || i_byte == cle_pkg::CH_LF) begin
            o_plan.busy      = 1'b1;
            o_plan.tab_start = cle_pkg::TAB_NL;
            o_plan.tab_end   = cle_pkg::TAB_NL;
            o_plan.line_len  = dlv_len;
            o_plan.line_kind = cle_pkg::KIND_LINE;
            o_plan.has_end   = 1'b1;
            o_plan.fill_next = '0;
            o_plan.cr_next   = (i_byte == cle_pkg::CH_CR);
        end else if (i_byte == cle_pkg::CH_ETX) begin
            o_plan.busy      = 1'b1;
            o_plan.tab_start = cle_pkg::TAB_INTR;
            o_plan.tab_end   = cle_pkg::TAB_INTR_END;
            o_plan.has_end   = 1'b1;
            o_plan.fill_next = '0;
        end else if (i_byte == cle_pkg::CH_FF) begin
            o_plan.busy      = 1'b1;
            o_plan.tab_start = cle_pkg::TAB_CLEAR;
            o_plan.tab_end   = cle_pkg::TAB_CLEAR_END;
            o_plan.line_len  = i_fill;
        end else if (i_byte == cle_pkg::CH_BS || i_byte == cle_pkg::CH_DEL) begin
            if (i_fill != '0) begin
                o_plan.busy      = 1'b1;
                o_plan.tab_start = cle_pkg::TAB_ERASE;
                o_plan.tab_end   = cle_pkg::TAB_ERASE_END;
                o_plan.fill_next = i_fill - cle_pkg::FILL_W'(1);
            end
        end else if (i_byte >= cle_pkg::CH_SP && i_byte <= cle_pkg::CH_TLD) begin
            o_plan.busy = 1'b1;
            if (has_room) begin
                o_plan.use_char  = 1'b1;
                o_plan.mem_wr    = 1'b1;
                o_plan.fill_next = i_fill + cle_pkg::FILL_W'(1);
            end else begin
                o_plan.tab_start = cle_pkg::TAB_BELL;
                o_plan.tab_end   = cle_pkg::TAB_BELL;
            end
        end else begin
            o_plan.busy = 1'b0;
        end
    end

endmodule

/* rtl/core/console_line_editor.sv */
// ----------------------------------------------------------------------------
// console_line_editor
// Line editor for a serial console: edits a stored line from received bytes
// and emits echo bytes, finished line bytes and end-of-line markers.
// ----------------------------------------------------------------------------
// Input words (i_in_byte) are taken with i_in_valid/o_in_ready; results leave
// on o_out_* with o_out_valid/i_out_ready, o_last marking the final result of
// each input byte. A byte that causes no result only updates state.
// The line lives in a LINE_SIZE-entry RAM with a registered read; it is
// written when a printable byte is accepted and the line has room, and read
// back one address ahead while a line or a redraw is streamed out.
// The block takes one input byte at a time: o_in_ready is high only while no
// results of the previous byte remain to be generated. Results leave one per
// cycle through the single output register while the receiver is ready.
// A stalled receiver simply holds the output register; generation waits.
// Reset (synchronous, active low) empties the line, clears the CR flag and
// sets the output capacity to 32. i_cfg_we writes the capacity at once.
// ----------------------------------------------------------------------------
module console_line_editor #(
    parameter int unsigned LINE_SIZE = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_out_kind,
    output logic [7:0]  o_out_byte,
    output logic [5:0]  o_delivered_length,
    output logic        o_last
);

    localparam int unsigned AW = $clog2(LINE_SIZE);
    localparam int unsigned FW = cle_pkg::FILL_W;

    cle_pkg::t_state r_state, n_state;
    cle_pkg::t_plan  plan;

    logic [FW-1:0]             r_fill, r_len, r_idx, idx_inc;
    logic                      r_cr;
    logic [7:0]                r_cap;
    logic [7:0]                r_char;
    logic [cle_pkg::TAB_W-1:0] r_ptr, r_ptr_end;
    cle_pkg::t_kind            r_line_kind;
    logic                      r_has_end;

    logic [7:0] r_line_mem [LINE_SIZE];
    logic [7:0] r_rd_data;

    logic       r_o_valid;
    logic [1:0] r_o_kind;
    logic [7:0] r_o_byte;
    logic [5:0] r_o_len;
    logic       r_o_last;

    logic           accept, out_free, emit, emit_last, rd_en;
    logic [AW-1:0]  rd_addr;
    cle_pkg::t_kind emit_kind;
    logic [7:0]     emit_byte;
    logic [FW-1:0]  emit_len;
    logic           tab_done, line_done;

    cle_decode #(
        .LINE_SIZE (LINE_SIZE)
    ) u_decode (
        .i_byte (i_in_byte),
        .i_fill (r_fill),
        .i_cr   (r_cr),
        .i_cap  (r_cap),
        .o_plan (plan)
    );

    assign o_in_ready = (r_state == cle_pkg::ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_o_valid || i_out_ready;
    assign idx_inc    = r_idx + FW'(1);
    assign tab_done   = (r_ptr == r_ptr_end);
    assign line_done  = (idx_inc == r_len);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cle_pkg::ST_IDLE: begin
                if (accept && plan.busy) begin
                    n_state = plan.use_char ? cle_pkg::ST_CHAR : cle_pkg::ST_TAB;
                end
            end
            cle_pkg::ST_CHAR: begin
                if (out_free) n_state = cle_pkg::ST_IDLE;
            end
            cle_pkg::ST_TAB: begin
                if (out_free && tab_done) begin
                    priority if (r_len != '0) n_state = cle_pkg::ST_LINE;
                    else if (r_has_end)       n_state = cle_pkg::ST_END;
                    else                      n_state = cle_pkg::ST_IDLE;
                end
            end
            cle_pkg::ST_LINE: begin
                if (out_free && line_done) begin
                    n_state = r_has_end ? cle_pkg::ST_END : cle_pkg::ST_IDLE;
                end
            end
            cle_pkg::ST_END: begin
                if (out_free) n_state = cle_pkg::ST_IDLE;
            end
            default: n_state = cle_pkg::ST_IDLE;
        endcase
    end

    // Result generation and line RAM read requests. The read for the next
    // line byte is issued as the current one leaves, so data is always ready.
    always_comb begin
        emit      = 1'b0;
        emit_kind = cle_pkg::KIND_ECHO;
        emit_byte = 8'h00;
        emit_len  = '0;
        emit_last = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = '0;
        unique case (r_state)
            cle_pkg::ST_IDLE: begin
                emit = 1'b0;
            end
            cle_pkg::ST_CHAR: begin
                emit      = out_free;
                emit_byte = r_char;
                emit_last = 1'b1;
            end
            cle_pkg::ST_TAB: begin
                emit      = out_free;
                emit_byte = cle_pkg::echo_rom(r_ptr);
                emit_last = tab_done && (r_len == '0) && !r_has_end;
                rd_en     = out_free && tab_done && (r_len != '0);
            end
            cle_pkg::ST_LINE: begin
                emit      = out_free;
                emit_kind = r_line_kind;
                emit_byte = r_rd_data;
                emit_last = line_done && !r_has_end;
                rd_en     = out_free && !line_done;
                rd_addr   = idx_inc[AW-1:0];
            end
            cle_pkg::ST_END: begin
                emit      = out_free;
                emit_kind = cle_pkg::KIND_END;
                emit_len  = r_len;
                emit_last = 1'b1;
            end
            default: emit = 1'b0;
        endcase
    end

    // Line RAM: written only on acceptance, read only while busy, so a read
    // never meets a write to the same entry.
    always_ff @(posedge i_clk) begin
        if (accept && plan.mem_wr) begin
            r_line_mem[r_fill[AW-1:0]] <= i_in_byte;
        end
        if (rd_en) begin
            r_rd_data <= r_line_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= cle_pkg::ST_IDLE;
            r_fill    <= '0;
            r_cr      <= 1'b0;
            r_cap     <= 8'd32;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (accept) begin
                r_fill <= plan.fill_next;
                r_cr   <= plan.cr_next;
            end
            if (emit) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Job and output payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_char      <= i_in_byte;
            r_ptr       <= plan.tab_start;
            r_ptr_end   <= plan.tab_end;
            r_len       <= plan.line_len;
            r_line_kind <= plan.line_kind;
            r_has_end   <= plan.has_end;
            r_idx       <= '0;
        end else if (emit && r_state == cle_pkg::ST_TAB && !tab_done) begin
            r_ptr <= r_ptr + cle_pkg::TAB_W'(1);
        end else if (emit && r_state == cle_pkg::ST_LINE) begin
            r_idx <= idx_inc;
        end
        if (emit) begin
            r_o_kind <= emit_kind;
            r_o_byte <= emit_byte;
            r_o_len  <= emit_len;
            r_o_last <= emit_last;
        end
    end

    assign o_out_valid        = r_o_valid;
    assign o_out_kind         = r_o_kind;
    assign o_out_byte         = r_o_byte;
    assign o_delivered_length = r_o_len;
    assign o_last             = r_o_last;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(LINE_SIZE - 1))
        else $error("fill count beyond line capacity");

    a_line_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cle_pkg::ST_LINE) |-> (r_idx < r_len))
        else $error("line index past line length");

    a_tab_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cle_pkg::ST_TAB) |-> (r_ptr <= r_ptr_end))
        else $error("echo pointer past sequence end");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && emit_last) |=> (r_state == cle_pkg::ST_IDLE))
        else $error("final result sent but sequencer still busy");

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// Console line editor testbench
// Feeds received bytes into console_line_editor and checks every result word
// against a cycle-free model of the line discipline or the table's typed words.
// A short table of directed bytes comes first, then random lines with edits,
// redraws and noise under several idle and stall patterns and output capacities.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LINE_SIZE = 32;
    localparam logic [7:0]  CH_BEL    = 8'h07;
    // Echo strings, first byte in the top bits.
    localparam logic [55:0] CLEAR_SEQ  = 56'h1b5b324a1b5b48;
    localparam logic [55:0] PROMPT_SEQ = 56'h7069636f783e20;
    localparam logic [23:0] ERASE_SEQ  = 24'h082008;
    localparam logic [23:0] INTR_SEQ   = 24'h5e430a;
    localparam int          HOLD_CYCLES = 400;

    typedef struct packed {
        cle_pkg::t_kind kind;
        logic [7:0]     data;
        logic [5:0]     len;
        logic           last;
    } t_word;

    typedef enum {ROW_BYTE, ROW_CFG} t_row_op;

    typedef struct {
        t_row_op     op;
        logic [7:0]  value;
        int          typed_n;   // -1: expected words come from the model
        t_word       typed [4];
    } t_row;

    localparam t_word NO_WORD = '0;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [7:0]  i_cfg_data = 8'h00;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_in_byte = 8'h00;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_out_kind;
    logic [7:0]  o_out_byte;
    logic [5:0]  o_delivered_length;
    logic        o_last;

    // Model state of the line editor.
    logic [7:0]  line_store [LINE_SIZE];
    int unsigned fill_level = 0;
    bit          cr_seen = 1'b0;
    int unsigned capacity = 32;

    t_word       expected_words [$];
    t_row        dir_table [$];
    int          error_count = 0;
    int          worded_items = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          hold_armed = 1'b0;
    bit          hold_done = 1'b0;
    int          hold_left = 0;

    console_line_editor #(
        .LINE_SIZE(LINE_SIZE)
    ) i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_in_byte          (i_in_byte),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_out_kind         (o_out_kind),
        .o_out_byte         (o_out_byte),
        .o_delivered_length (o_delivered_length),
        .o_last             (o_last)
    );

    always #4 i_clk = ~i_clk;

    task automatic report_error(input string msg);
        if (error_count < 50) begin
            $display("ERROR at %0t ns: %s", $time, msg);
        end
        error_count++;
    endtask

    function automatic t_word echo_word(input logic [7:0] b);
        t_word w;
        w = '0;
        w.kind = cle_pkg::KIND_ECHO;
        w.data = b;
        return w;
    endfunction

    function automatic t_word end_word(input logic [5:0] len);
        t_word w;
        w = '0;
        w.kind = cle_pkg::KIND_END;
        w.len = len;
        return w;
    endfunction

    // Works out the words one received byte causes and updates the model state.
    function automatic void predict_editor(input logic [7:0] c, ref t_word res[$]);
        int unsigned len;
        t_word       w;
        res.delete();
        if (c == cle_pkg::CH_LF && cr_seen) begin
            cr_seen = 1'b0;
        end else if (c == cle_pkg::CH_CR || c == cle_pkg::CH_LF) begin
            cr_seen = (c == cle_pkg::CH_CR);
            res.push_back(echo_word(cle_pkg::CH_LF));
            if (capacity == 0) begin
                len = 0;
            end else begin
                len = (fill_level > capacity - 1) ? capacity - 1 : fill_level;
            end
            for (int i = 0; i < len; i++) begin
                w = echo_word(line_store[i]);
                w.kind = cle_pkg::KIND_LINE;
                res.push_back(w);
            end
            res.push_back(end_word(6'(len)));
            fill_level = 0;
        end else begin
            cr_seen = 1'b0;
            if (c == cle_pkg::CH_ETX) begin
                for (int i = 0; i < 3; i++) begin
                    res.push_back(echo_word(INTR_SEQ[23 - 8*i -: 8]));
                end
                fill_level = 0;
                res.push_back(end_word(6'd0));
            end else if (c == cle_pkg::CH_FF) begin
                for (int i = 0; i < 7; i++) begin
                    res.push_back(echo_word(CLEAR_SEQ[55 - 8*i -: 8]));
                end
                for (int i = 0; i < 7; i++) begin
                    res.push_back(echo_word(PROMPT_SEQ[55 - 8*i -: 8]));
                end
                for (int i = 0; i < fill_level; i++) begin
                    res.push_back(echo_word(line_store[i]));
                end
            end else if (c == cle_pkg::CH_BS || c == cle_pkg::CH_DEL) begin
                if (fill_level > 0) begin
                    fill_level--;
                    for (int i = 0; i < 3; i++) begin
                        res.push_back(echo_word(ERASE_SEQ[23 - 8*i -: 8]));
                    end
                end
            end else if (c >= cle_pkg::CH_SP && c <= cle_pkg::CH_TLD) begin
                if (fill_level < LINE_SIZE - 1) begin
                    line_store[fill_level] = c;
                    fill_level++;
                    res.push_back(echo_word(c));
                end else begin
                    res.push_back(echo_word(CH_BEL));
                end
            end
        end
        if (res.size() > 0) begin
            res[res.size() - 1].last = 1'b1;
        end
    endfunction

    function automatic void add_row(input t_row_op op, input logic [7:0] value, input int n,
                                    input t_word w0, input t_word w1,
                                    input t_word w2, input t_word w3);
        t_row r;
        r.op = op;
        r.value = value;
        r.typed_n = n;
        r.typed[0] = w0;
        r.typed[1] = w1;
        r.typed[2] = w2;
        r.typed[3] = w3;
        dir_table.push_back(r);
    endfunction

    // Offers one word, waits for it to be taken and queues what it should cause.
    task automatic send_byte(input logic [7:0] b, input int row_idx);
        t_word pred [$];
        t_word w;
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
        predict_editor(b, pred);
        if (row_idx >= 0 && dir_table[row_idx].typed_n >= 0) begin
            for (int i = 0; i < dir_table[row_idx].typed_n; i++) begin
                w = dir_table[row_idx].typed[i];
                w.last = (i == dir_table[row_idx].typed_n - 1);
                expected_words.push_back(w);
            end
        end else begin
            foreach (pred[i]) expected_words.push_back(pred[i]);
        end
        if (pred.size() > 0) begin
            worded_items++;
        end
    endtask

    // The capacity is only changed while the block has nothing left to do.
    task automatic write_capacity(input logic [7:0] value);
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        capacity = value;
    endtask

    // A typed line with edits and redraws, ended in one of several ways or not at all.
    task automatic send_line();
        int n;
        int r;
        n = ($urandom_range(9) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 10);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 8) begin
                send_byte($urandom_range(1) ? cle_pkg::CH_BS : cle_pkg::CH_DEL, -1);
            end else if (r < 11) begin
                send_byte(cle_pkg::CH_FF, -1);
            end else begin
                send_byte(8'($urandom_range(cle_pkg::CH_SP, cle_pkg::CH_TLD)), -1);
            end
        end
        r = $urandom_range(99);
        if (r < 45) begin
            send_byte(cle_pkg::CH_CR, -1);
        end else if (r < 65) begin
            send_byte(cle_pkg::CH_CR, -1);
            send_byte(cle_pkg::CH_LF, -1);
        end else if (r < 80) begin
            send_byte(cle_pkg::CH_LF, -1);
        end else if (r < 92) begin
            send_byte(cle_pkg::CH_ETX, -1);
        end
    endtask

    // Result words are checked in order against the queued expectations.
    always @(posedge i_clk) begin : out_side
        t_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_words.size() == 0) begin
                report_error($sformatf("unexpected word kind %0d byte %h length %0d",
                                       o_out_kind, o_out_byte, o_delivered_length));
            end else begin
                want = expected_words.pop_front();
                if (o_out_kind != want.kind) begin
                    report_error($sformatf("kind %0d, expected %0d", o_out_kind, want.kind));
                end
                if (o_out_byte != want.data) begin
                    report_error($sformatf("byte %h, expected %h", o_out_byte, want.data));
                end
                if (o_delivered_length != want.len) begin
                    report_error($sformatf("length %0d, expected %0d",
                                           o_delivered_length, want.len));
                end
                if (o_last != want.last) begin
                    report_error($sformatf("last %0b, expected %0b", o_last, want.last));
                end
            end
        end
    end

    // Receiver readiness, including the one long hold-off counted in cycles.
    always @(posedge i_clk) begin : recv_side
        if (hold_armed && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
        end
        i_out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        #4ms;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        int start;
        int caps [4];
        int idle_pct [4];
        int stall_pct [4];

        add_row(ROW_BYTE, cle_pkg::CH_CR,  2, echo_word(cle_pkg::CH_LF), end_word(6'd0),
                NO_WORD, NO_WORD);
        add_row(ROW_BYTE, cle_pkg::CH_LF,  0, NO_WORD, NO_WORD, NO_WORD, NO_WORD);
        add_row(ROW_BYTE, cle_pkg::CH_LF,  2, echo_word(cle_pkg::CH_LF), end_word(6'd0),
                NO_WORD, NO_WORD);
        add_row(ROW_BYTE, cle_pkg::CH_BS,  0, NO_WORD, NO_WORD, NO_WORD, NO_WORD);
        add_row(ROW_BYTE, cle_pkg::CH_SP,  1, echo_word(cle_pkg::CH_SP), NO_WORD, NO_WORD,
                NO_WORD);
        add_row(ROW_BYTE, cle_pkg::CH_TLD, 1, echo_word(cle_pkg::CH_TLD), NO_WORD, NO_WORD,
                NO_WORD);
        add_row(ROW_BYTE, 8'h00,  0, NO_WORD, NO_WORD, NO_WORD, NO_WORD);
        add_row(ROW_BYTE, 8'hff,  0, NO_WORD, NO_WORD, NO_WORD, NO_WORD);
        add_row(ROW_BYTE, 8'h80,  0, NO_WORD, NO_WORD, NO_WORD, NO_WORD);
        add_row(ROW_BYTE, 8'h1f,  0, NO_WORD, NO_WORD, NO_WORD, NO_WORD);
        add_row(ROW_BYTE, cle_pkg::CH_FF, -1, NO_WORD, NO_WORD, NO_WORD, NO_WORD);
        add_row(ROW_BYTE, cle_pkg::CH_DEL, 3, echo_word(8'h08), echo_word(8'h20),
                echo_word(8'h08), NO_WORD);
        add_row(ROW_BYTE, cle_pkg::CH_CR, -1, NO_WORD, NO_WORD, NO_WORD, NO_WORD);
        add_row(ROW_BYTE, 8'h41,  1, echo_word(8'h41), NO_WORD, NO_WORD, NO_WORD);
        add_row(ROW_BYTE, cle_pkg::CH_ETX, 4, echo_word(8'h5e), echo_word(8'h43),
                echo_word(cle_pkg::CH_LF), end_word(6'd0));
        // Capacity one delivers nothing, capacity zero likewise.
        add_row(ROW_CFG,  8'd1,   0, NO_WORD, NO_WORD, NO_WORD, NO_WORD);
        add_row(ROW_BYTE, 8'h71,  1, echo_word(8'h71), NO_WORD, NO_WORD, NO_WORD);
        add_row(ROW_BYTE, cle_pkg::CH_CR,  2, echo_word(cle_pkg::CH_LF), end_word(6'd0),
                NO_WORD, NO_WORD);
        add_row(ROW_CFG,  8'd0,   0, NO_WORD, NO_WORD, NO_WORD, NO_WORD);
        add_row(ROW_BYTE, 8'h7a,  1, echo_word(8'h7a), NO_WORD, NO_WORD, NO_WORD);
        add_row(ROW_BYTE, cle_pkg::CH_LF,  2, echo_word(cle_pkg::CH_LF), end_word(6'd0),
                NO_WORD, NO_WORD);
        add_row(ROW_CFG,  8'd255, 0, NO_WORD, NO_WORD, NO_WORD, NO_WORD);
        add_row(ROW_BYTE, 8'h6b, -1, NO_WORD, NO_WORD, NO_WORD, NO_WORD);
        add_row(ROW_BYTE, cle_pkg::CH_CR, -1, NO_WORD, NO_WORD, NO_WORD, NO_WORD);
        add_row(ROW_CFG,  8'd2,   0, NO_WORD, NO_WORD, NO_WORD, NO_WORD);
        add_row(ROW_BYTE, 8'h6d, -1, NO_WORD, NO_WORD, NO_WORD, NO_WORD);
        add_row(ROW_BYTE, 8'h6e, -1, NO_WORD, NO_WORD, NO_WORD, NO_WORD);
        add_row(ROW_BYTE, cle_pkg::CH_CR, -1, NO_WORD, NO_WORD, NO_WORD, NO_WORD);
        add_row(ROW_BYTE, cle_pkg::CH_LF,  0, NO_WORD, NO_WORD, NO_WORD, NO_WORD);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_table[r]) begin
            if (dir_table[r].op == ROW_CFG) begin
                write_capacity(dir_table[r].value);
            end else begin
                send_byte(dir_table[r].value, r);
            end
        end

        caps[0] = $urandom_range(2, 40);
        caps[1] = 255;
        caps[2] = $urandom_range(0, 255);
        caps[3] = 32;
        idle_pct  = '{0, 59, 0, 7};
        stall_pct = '{0, 0, 59, 7};
        for (int p = 0; p < 4; p++) begin
            write_capacity(8'(caps[p]));
            send_idle_pct = idle_pct[p];
            recv_stall_pct = stall_pct[p];
            // The long receiver hold-off lands in the first random phase.
            if (p == 0) begin
                hold_armed = 1'b1;
            end
            start = worded_items;
            while (worded_items - start < 100) begin
                if ($urandom_range(99) < 80) begin
                    send_line();
                end else begin
                    repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(255)), -1);
                end
            end
        end

        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

/* filelist.f */
rtl/core/cle_pkg.sv
rtl/core/cle_decode.sv
rtl/core/console_line_editor.sv
test/testbench.sv
